>>> design/tqqs_pkg.sv
package tqqs_pkg;

  // Fixed field widths of the ports
  localparam int OP_W       = 1;
  localparam int SEL_W      = 2;
  localparam int IN_WORK_W  = 16;
  localparam int QUANTUM_W  = 16;
  localparam int QID_W      = 2;
  localparam int NUM_W      = 16;
  localparam int NUM_QUEUES = 3;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd1;

  // Selector code with no queue behind it, and the queue number of an idle result
  localparam logic [SEL_W-1:0] SEL_NONE = 2'd3;
  localparam logic [QID_W-1:0] QID_NONE = 2'd0;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ   = 1'b0,
    OP_ROUND = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_e;

  // One result transaction, without the framing bits
  typedef struct packed {
    kind_e             kind;
    logic [QID_W-1:0]  queue_id;
    logic [NUM_W-1:0]  client_number;
  } result_t;

  // Status of one queue towards the top level
  typedef struct packed {
    logic             full;
    logic             empty;
    logic             done;
    logic             empty_next;
    logic [NUM_W-1:0] number;
  } qstat_t;

endpackage

>>> design/tqqs_queue.sv
module tqqs_queue
  import tqqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int WORK_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 enq_i,
  input  logic [WORK_BITS-1:0] enq_work_i,
  input  logic                 serve_i,
  input  logic [QUANTUM_W-1:0] quantum_i,
  output qstat_t               stat_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (WORK_BITS > QUANTUM_W) ? WORK_BITS : QUANTUM_W;
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(QUEUE_DEPTH);

  logic [WORK_BITS-1:0] mem_q [QUEUE_DEPTH];
  logic [WORK_BITS-1:0] head_work_q;
  logic [PTR_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [NUM_W-1:0]     done_q, done_d;

  logic [PTR_W:0]       tail_sum;
  logic [PTR_W-1:0]     tail;
  logic [PTR_W-1:0]     head_inc;
  logic                 full, empty, fits, served;
  logic                 wr_en;
  logic [PTR_W-1:0]     wr_addr;
  logic [WORK_BITS-1:0] wr_data;
  logic [WORK_BITS-1:0] rest;

  // Locate the free slot behind the last client and the slot after the head
  assign tail_sum = {1'b0, head_q} + (PTR_W + 1)'(count_q);
  assign tail     = (tail_sum >= DEPTH_X) ? PTR_W'(tail_sum - DEPTH_X) : PTR_W'(tail_sum);
  assign head_inc = (head_q == LAST_PTR) ? '0 : head_q + 1'b1;

  assign full   = (count_q == DEPTH_C);
  assign empty  = (count_q == '0);
  assign served = serve_i && !empty;
  assign fits   = (CMP_W'(head_work_q) <= CMP_W'(quantum_i));
  assign rest   = head_work_q - WORK_BITS'(quantum_i);

  // Append a client, or serve the head for one quantum
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    done_d  = done_q;
    wr_en   = 1'b0;
    wr_addr = tail;
    wr_data = enq_work_i;
    if (enq_i) begin
      wr_en   = 1'b1;
      count_d = count_q + 1'b1;
    end else if (served) begin
      if (fits) begin
        head_d  = head_inc;
        count_d = count_q - 1'b1;
        done_d  = done_q + 1'b1;
      end else begin
        wr_en   = 1'b1;
        wr_addr = head_q;
        wr_data = rest;
      end
    end
  end

  assign stat_o.full       = full;
  assign stat_o.empty      = empty;
  assign stat_o.done       = served && fits;
  assign stat_o.empty_next = (count_d == '0);
  assign stat_o.number     = done_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      done_q  <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Store client work; keep the next head's work registered, with write bypass
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == head_d)) begin
      head_work_q <= wr_data;
    end else begin
      head_work_q <= mem_q[head_d];
    end
  end

endmodule

>>> design/tqqs_res_buf.sv
module tqqs_res_buf
  import tqqs_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  result_t [NUM_QUEUES-1:0]    slots_i,
  input  logic [1:0]                  count_i,
  input  logic                        all_empty_i,
  output logic                        free_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output result_t                     res_o,
  output logic                        last_o,
  output logic                        all_empty_o
);

  result_t [NUM_QUEUES-1:0] res_q;
  logic                     all_empty_q;
  logic [1:0]               rem_q, rem_d;
  logic [1:0]               ptr_q, ptr_d;
  logic                     pop;

  assign out_valid_o = (rem_q != 2'd0);
  assign last_o      = (rem_q == 2'd1);
  assign pop         = out_valid_o && out_ready_i;
  // Take new results when none are pending or the last pending one leaves
  assign free_o      = !out_valid_o || (last_o && out_ready_i);
  assign res_o       = res_q[ptr_q];
  assign all_empty_o = all_empty_q;

  // Advance through the buffered results, or reload
  always_comb begin
    rem_d = rem_q;
    ptr_d = ptr_q;
    if (load_i) begin
      rem_d = count_i;
      ptr_d = 2'd0;
    end else if (pop) begin
      rem_d = rem_q - 2'd1;
      ptr_d = ptr_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      ptr_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q       <= slots_i;
      all_empty_q <= all_empty_i;
    end
  end

endmodule

>>> design/three_queue_quantum_scheduler_core.sv
// Three-queue round-robin time-slice scheduler. An enqueue transaction appends a
// client to queue 1, 2 or 3 and gives one result (accepted, or rejected when the
// queue is full or the selector names no queue). A round transaction serves the
// heads of queues 1, 2 and 3 in order, subtracting the quantum, and gives one
// completion result per client that finishes, or a single idle result. Each item
// waits in the input register until the result buffer is free; the queue logic
// then acts on it and its results are loaded into the result buffer, which
// presents them. A new item is taken every cycle as long as results are drained.
// A round with n completions gives n results (one to three), which the
// single-result output port presents in turn; this sets the sustained rate. Each
// queue keeps its clients in a QUEUE_DEPTH-entry memory with a registered read of
// its head entry; no clearing pass follows reset.
module three_queue_quantum_scheduler_core
  import tqqs_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int WORK_BITS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 quantum_we_i,
  input  logic [QUANTUM_W-1:0] quantum_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [SEL_W-1:0]     queue_sel_i,
  input  logic [IN_WORK_W-1:0] work_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           kind_o,
  output logic [QID_W-1:0]     queue_id_o,
  output logic [NUM_W-1:0]     client_number_o,
  output logic                 last_o,
  output logic                 all_empty_o
);

  logic [QUANTUM_W-1:0]     quantum_q;
  logic                     in_valid_q;
  op_e                      op_q;
  logic [SEL_W-1:0]         sel_q;
  logic [IN_WORK_W-1:0]     work_q;

  qstat_t [NUM_QUEUES-1:0]  stat;
  logic   [NUM_QUEUES-1:0]  enq_we;
  logic                     serve;
  logic                     fire;
  logic                     buf_free;
  result_t [NUM_QUEUES-1:0] slots;
  logic [1:0]               n_res;
  logic                     sel_full;
  logic                     all_empty;
  result_t                  res;

  // Quantum register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RESET;
    end else if (quantum_we_i) begin
      quantum_q <= quantum_i;
    end
  end

  // Input register: hold the transaction until the queues act on it
  assign fire       = in_valid_q && buf_free;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= op_e'(op_i);
      sel_q  <= queue_sel_i;
      work_q <= work_i;
    end
  end

  // Queue commands
  assign serve = fire && (op_q == OP_ROUND);

  always_comb begin
    sel_full = 1'b0;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if (sel_q == SEL_W'(q) && stat[q].full) begin
        sel_full = 1'b1;
      end
      enq_we[q] = fire && (op_q == OP_ENQ) && (sel_q == SEL_W'(q)) && !stat[q].full;
    end
  end

  for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_queue
    tqqs_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .WORK_BITS   (WORK_BITS)
    ) u_queue (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .enq_i      (enq_we[g]),
      .enq_work_i (WORK_BITS'(work_q)),
      .serve_i    (serve),
      .quantum_i  (quantum_q),
      .stat_o     (stat[g])
    );
  end

  // Build the result list: one enqueue answer, completions in queue order, or idle
  always_comb begin
    slots = '0;
    n_res = 2'd0;
    if (op_q == OP_ENQ) begin
      slots[0].kind     = (sel_q == SEL_NONE || sel_full) ? KIND_REJECT : KIND_ACCEPT;
      slots[0].queue_id = (sel_q == SEL_NONE) ? QID_NONE : QID_W'(sel_q + 2'd1);
      n_res             = 2'd1;
    end else begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        if (stat[q].done) begin
          slots[n_res].kind          = KIND_DONE;
          slots[n_res].queue_id      = QID_W'(q + 1);
          slots[n_res].client_number = stat[q].number;
          n_res                      = n_res + 2'd1;
        end
      end
      if (n_res == 2'd0) begin
        slots[0].kind = KIND_IDLE;
        n_res         = 2'd1;
      end
    end
  end

  assign all_empty = stat[0].empty_next && stat[1].empty_next && stat[2].empty_next;

  tqqs_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .slots_i     (slots),
    .count_i     (n_res),
    .all_empty_i (all_empty),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res),
    .last_o      (last_o),
    .all_empty_o (all_empty_o)
  );

  assign kind_o          = res.kind;
  assign queue_id_o      = res.queue_id;
  assign client_number_o = res.client_number;

`ifndef SYNTH
  // A round over empty queues gives exactly one idle result
  a_idle_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    serve && stat[0].empty && stat[1].empty && stat[2].empty
    |=> out_valid_o && kind_o == KIND_IDLE && last_o)
    else $error("idle round did not yield a single idle result");

  // The empty flag shown matches the queue state while results are pending
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> all_empty_o == (stat[0].empty && stat[1].empty && stat[2].empty))
    else $error("all_empty disagrees with queue occupancy");

  // A completion always names a real queue
  a_done_qid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_DONE |-> queue_id_o != QID_NONE)
    else $error("completion without a queue number");

  // An enqueue transaction gives one result, marked last
  a_enq_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && op_q == OP_ENQ |=> out_valid_o && last_o &&
      (kind_o == KIND_ACCEPT || kind_o == KIND_REJECT))
    else $error("enqueue did not give a single answer");
`endif

endmodule

>>> bench/tb.sv
module tb;
  import tqqs_pkg::*;

  localparam int DEPTH = 16;

  // Expected result transaction with its framing bits
  typedef struct packed {
    result_t body;
    logic    last;
    logic    all_empty;
  } sched_result_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 quantum_we_i = 1'b0;
  logic [QUANTUM_W-1:0] quantum_i    = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [OP_W-1:0]      op_i         = '0;
  logic [SEL_W-1:0]     queue_sel_i  = '0;
  logic [IN_WORK_W-1:0] work_i       = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [1:0]           kind_o;
  logic [QID_W-1:0]     queue_id_o;
  logic [NUM_W-1:0]     client_number_o;
  logic                 last_o;
  logic                 all_empty_o;

  three_queue_quantum_scheduler_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .quantum_we_i   (quantum_we_i),
    .quantum_i      (quantum_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .queue_sel_i    (queue_sel_i),
    .work_i         (work_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .queue_id_o     (queue_id_o),
    .client_number_o(client_number_o),
    .last_o         (last_o),
    .all_empty_o    (all_empty_o)
  );

  // Scheduler image kept alongside the block
  logic [IN_WORK_W-1:0] sched_work [NUM_QUEUES][DEPTH];
  int unsigned          sched_head [NUM_QUEUES];
  int unsigned          sched_count[NUM_QUEUES];
  logic [NUM_W-1:0]     sched_done [NUM_QUEUES];
  logic [QUANTUM_W-1:0] sched_quantum;

  sched_result_t awaited_results[$];

  int unsigned error_count    = 0;
  int unsigned items_sent     = 0;
  int unsigned done_seen      = 0;
  int unsigned reject_seen    = 0;
  int unsigned idle_seen      = 0;
  int unsigned quantum_writes = 0;
  int unsigned burst_left     = 1;

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Stop a hung run
  initial begin
    #5000000;
    $display("Timeout with %0d results still awaited", awaited_results.size());
    $display("three_queue_quantum_scheduler_core verification failed");
    $finish;
  end

  // Work out the results of one accepted transaction and queue them
  function automatic void predict_schedule(op_e op, logic [SEL_W-1:0] sel,
                                           logic [IN_WORK_W-1:0] w);
    sched_result_t batch[3];
    int            n;
    int unsigned   q;
    int unsigned   slot;
    logic          drained;
    n = 0;
    for (int k = 0; k < 3; k++) batch[k] = '0;
    if (op == OP_ENQ) begin
      if (sel == SEL_NONE) begin
        batch[0].body.kind = KIND_REJECT;
        batch[0].body.queue_id = QID_NONE;
      end else if (sched_count[sel] >= DEPTH) begin
        batch[0].body.kind = KIND_REJECT;
        batch[0].body.queue_id = sel + 2'd1;
      end else begin
        slot = (sched_head[sel] + sched_count[sel]) % DEPTH;
        sched_work[sel][slot] = w;
        sched_count[sel]++;
        batch[0].body.kind = KIND_ACCEPT;
        batch[0].body.queue_id = sel + 2'd1;
      end
      n = 1;
    end else begin
      // Serve each non-empty head in queue order
      for (q = 0; q < NUM_QUEUES; q++) begin
        if (sched_count[q] != 0) begin
          if (sched_work[q][sched_head[q]] <= sched_quantum) begin
            sched_head[q] = (sched_head[q] + 1) % DEPTH;
            sched_count[q]--;
            sched_done[q] = sched_done[q] + 16'd1;
            batch[n].body.kind = KIND_DONE;
            batch[n].body.queue_id = QID_W'(q + 1);
            batch[n].body.client_number = sched_done[q];
            n++;
          end else begin
            sched_work[q][sched_head[q]] = sched_work[q][sched_head[q]] - sched_quantum;
          end
        end
      end
      if (n == 0) begin
        batch[0].body.kind = KIND_IDLE;
        batch[0].body.queue_id = QID_NONE;
        n = 1;
      end
    end
    drained = (sched_count[0] == 0) && (sched_count[1] == 0) && (sched_count[2] == 0);
    for (int k = 0; k < n; k++) begin
      batch[k].all_empty = drained;
      batch[k].last = (k == n - 1);
      awaited_results.push_back(batch[k]);
    end
  endfunction

  // Send one transaction; hold valid through a burst, drop it for a gap
  task automatic send_item(op_e op, logic [SEL_W-1:0] sel, logic [IN_WORK_W-1:0] w);
    in_valid_i  <= 1'b1;
    op_i        <= op;
    queue_sel_i <= sel;
    work_i      <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predict_schedule(op, sel, w);
    items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every awaited result has come back
  task automatic settle();
    if (in_valid_i) in_valid_i <= 1'b0;
    burst_left = $urandom_range(1, 12);
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_quantum(logic [QUANTUM_W-1:0] value);
    quantum_we_i <= 1'b1;
    quantum_i    <= value;
    @(posedge clk_i);
    quantum_we_i <= 1'b0;
    sched_quantum = value;
    quantum_writes++;
    @(posedge clk_i);
  endtask

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      error_count++;
    end
  endfunction

  // Receiver: rotate a stall pattern, renew it now and then
  logic [7:0]  stall_pattern = 8'hFF;
  int unsigned pattern_age   = 0;
  always @(posedge clk_i) begin
    if (pattern_age == 0) begin
      stall_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      pattern_age   <= $urandom_range(16, 96);
    end else begin
      stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
      pattern_age   <= pattern_age - 1;
    end
    out_ready_i <= stall_pattern[0];
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    sched_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      case (kind_o)
        KIND_DONE:   done_seen++;
        KIND_REJECT: reject_seen++;
        KIND_IDLE:   idle_seen++;
        default: ;
      endcase
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, kind %0d queue %0d number %0d", $time,
                 kind_o, queue_id_o, client_number_o);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("kind", 16'(want.body.kind), 16'(kind_o));
        check_field("queue_id", 16'(want.body.queue_id), 16'(queue_id_o));
        check_field("client_number", want.body.client_number, client_number_o);
        check_field("last", 16'(want.last), 16'(last_o));
        check_field("all_empty", 16'(want.all_empty), 16'(all_empty_o));
      end
    end
  end

  // Round on empty queues, and the selector with no queue behind it
  task automatic test_empty_cases();
    send_item(OP_ROUND, 2'd0, 16'd0);
    send_item(OP_ENQ, SEL_NONE, 16'hFFFF);
    send_item(OP_ROUND, SEL_NONE, 16'hFFFF);
    settle();
  endtask

  // Zero work, full-scale work, quantum extremes and zero quantum
  task automatic test_service_extremes();
    send_item(OP_ENQ, 2'd0, 16'd0);
    send_item(OP_ENQ, 2'd1, 16'hFFFF);
    send_item(OP_ENQ, 2'd2, 16'd1);
    send_item(OP_ENQ, 2'd0, 16'd2);
    send_item(OP_ROUND, 2'd0, 16'd0);
    send_item(OP_ROUND, 2'd2, 16'h5555);
    settle();
    write_quantum(16'hFFFF);
    send_item(OP_ROUND, 2'd1, 16'hAAAA);
    settle();
    write_quantum(16'd0);
    send_item(OP_ENQ, 2'd1, 16'd0);
    send_item(OP_ENQ, 2'd2, 16'd7);
    send_item(OP_ROUND, 2'd0, 16'd0);
    send_item(OP_ROUND, 2'd0, 16'd0);
    settle();
    write_quantum(16'hFFFF);
    send_item(OP_ROUND, 2'd0, 16'd0);
    settle();
  endtask

  // Overfill one queue so the last enqueue is turned away
  task automatic test_full_queue();
    for (int k = 0; k <= DEPTH; k++) send_item(OP_ENQ, 2'd0, 16'($urandom));
    send_item(OP_ROUND, 2'd0, 16'd0);
    settle();
  endtask

  // Mixed enqueues and rounds under several quantum settings
  task automatic test_random_traffic();
    logic [QUANTUM_W-1:0] quanta[6];
    logic [IN_WORK_W-1:0] w;
    logic [SEL_W-1:0]     sel;
    int unsigned          span;
    quanta[0] = 16'd1;
    quanta[1] = 16'($urandom_range(2, 300));
    quanta[2] = 16'hFFFF;
    quanta[3] = 16'd0;
    quanta[4] = 16'($urandom);
    quanta[5] = 16'($urandom_range(20, 60));
    for (int p = 0; p < 6; p++) begin
      write_quantum(quanta[p]);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 99) < 40) begin
          send_item(OP_ROUND, SEL_W'($urandom), 16'($urandom));
        end else begin
          sel = ($urandom_range(0, 15) == 0) ? SEL_NONE : SEL_W'($urandom_range(0, 2));
          span = 3 * int'(quanta[p]) + 3;
          if (span > 65535) span = 65535;
          case ($urandom_range(0, 7))
            0, 1:    w = 16'($urandom);
            2:       w = 16'd0;
            3:       w = 16'hFFFF;
            default: w = 16'($urandom_range(0, span));
          endcase
          send_item(OP_ENQ, sel, w);
        end
      end
      settle();
    end
  endtask

  initial begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      sched_head[q]  = 0;
      sched_count[q] = 0;
      sched_done[q]  = '0;
    end
    sched_quantum = QUANTUM_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_cases();
    test_service_extremes();
    test_full_queue();
    test_random_traffic();

    settle();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d transactions in, %0d quantum writes", items_sent, quantum_writes);
    $display("Results seen: %0d completions, %0d rejects, %0d idle rounds",
             done_seen, reject_seen, idle_seen);
    if (error_count == 0) begin
      $display("three_queue_quantum_scheduler_core verification clean");
    end else begin
      $display("three_queue_quantum_scheduler_core verification failed");
    end
    $finish;
  end

endmodule
